FILE: rtl/scacc_pkg.sv
// Package for the serial correlation accumulator: widths, state and
// product codes, and the command struct between controller and datapath.
// No dependencies.
`default_nettype none

package scacc_pkg;

    localparam int COUNT_BITS    = 32;
    localparam int FRACTION_BITS = 30;

    localparam int BYTE_BITS  = 8;
    localparam int SUM_BITS   = COUNT_BITS + BYTE_BITS;
    localparam int SQ_BITS    = COUNT_BITS + 2 * BYTE_BITS;
    localparam int DIGITS     = (SUM_BITS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int OPB_BITS   = DIGITS * BYTE_BITS;
    localparam int PP_BITS    = SQ_BITS + BYTE_BITS;
    localparam int PROD_BITS  = COUNT_BITS + SQ_BITS;
    localparam int REM_BITS   = PROD_BITS + 1;
    localparam int Q_BITS     = FRACTION_BITS + 2;
    localparam int SAT_BITS   = (Q_BITS > 33) ? Q_BITS : 33;
    localparam int DIV_STEPS  = FRACTION_BITS + 1;
    localparam int OUT_BITS   = 32;

    localparam int DIG_CNT_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam logic [DIG_CNT_BITS-1:0] DIG_LAST = DIG_CNT_BITS'(DIGITS - 1);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        ST_ACC,
        ST_WRAP,
        ST_MUL,
        ST_DEN,
        ST_NUM,
        ST_PRE,
        ST_FIX,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PR_SQR,
        PR_NQ,
        PR_NC
    } t_prod;

    typedef struct packed {
        logic                    acc;
        logic                    wrap;
        logic                    mul;
        t_prod                   psel;
        logic [DIG_CNT_BITS-1:0] dig;
        logic                    den;
        logic                    num;
        logic                    pre;
        logic                    fix;
        logic                    div;
        logic                    load;
        logic                    clr;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/scacc_in_if.sv
// Input channel: one byte per transaction with its end-of-block mark.
// No dependencies.
`default_nettype none

interface scacc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/scacc_out_if.sv
// Output channel: one correlation result per transaction with its flags.
// No dependencies.
`default_nettype none

interface scacc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] correlation;
    logic               undefined;
    logic               overflowed;

    modport source (output valid, output correlation, output undefined,
                    output overflowed, input ready);
    modport sink   (input valid, input correlation, input undefined,
                    input overflowed, output ready);
endinterface

`default_nettype wire

FILE: rtl/scacc_ctrl.sv
// Controller state machine: sequences accumulation, products, division
// and result hand-off. Depends on scacc_pkg.
`default_nettype none

module scacc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_last,
    input  wire logic             i_out_ready,
    input  wire logic             i_undef,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output scacc_pkg::t_cmd       o_cmd
);

    scacc_pkg::t_state                        r_state, n_state;
    scacc_pkg::t_prod                         r_psel, n_psel;
    logic [scacc_pkg::DIG_CNT_BITS-1:0]       r_dig, n_dig;
    logic [scacc_pkg::DIV_CNT_BITS-1:0]       r_div, n_div;
    logic                                     r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scacc_pkg::ST_ACC;
            r_psel      <= scacc_pkg::PR_SQR;
            r_dig       <= '0;
            r_div       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_psel      <= n_psel;
            r_dig       <= n_dig;
            r_div       <= n_div;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_psel  = r_psel;
        n_dig   = r_dig;
        n_div   = r_div;
        case (r_state)
            scacc_pkg::ST_ACC: begin
                if (i_in_valid && i_in_last) begin
                    n_state = scacc_pkg::ST_WRAP;
                end
            end
            scacc_pkg::ST_WRAP: begin
                n_state = scacc_pkg::ST_MUL;
                n_psel  = scacc_pkg::PR_SQR;
                n_dig   = '0;
            end
            scacc_pkg::ST_MUL: begin
                if (r_dig == scacc_pkg::DIG_LAST) begin
                    n_dig = '0;
                    case (r_psel)
                        scacc_pkg::PR_SQR: n_psel = scacc_pkg::PR_NQ;
                        scacc_pkg::PR_NQ:  n_psel = scacc_pkg::PR_NC;
                        default:           n_state = scacc_pkg::ST_DEN;
                    endcase
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            scacc_pkg::ST_DEN: n_state = scacc_pkg::ST_NUM;
            scacc_pkg::ST_NUM: begin
                n_state = i_undef ? scacc_pkg::ST_DONE : scacc_pkg::ST_PRE;
            end
            scacc_pkg::ST_PRE: n_state = scacc_pkg::ST_FIX;
            scacc_pkg::ST_FIX: begin
                n_state = scacc_pkg::ST_DIV;
                n_div   = '0;
            end
            scacc_pkg::ST_DIV: begin
                if (r_div == scacc_pkg::DIV_LAST) begin
                    n_state = scacc_pkg::ST_DONE;
                end else begin
                    n_div = r_div + 1'b1;
                end
            end
            scacc_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = scacc_pkg::ST_ACC;
                end
            end
            default: n_state = scacc_pkg::ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.psel = r_psel;
        o_cmd.dig  = r_dig;
        o_in_ready = 1'b0;
        case (r_state)
            scacc_pkg::ST_ACC: begin
                o_in_ready = 1'b1;
                o_cmd.acc  = i_in_valid;
            end
            scacc_pkg::ST_WRAP: o_cmd.wrap = 1'b1;
            scacc_pkg::ST_MUL:  o_cmd.mul  = 1'b1;
            scacc_pkg::ST_DEN:  o_cmd.den  = 1'b1;
            scacc_pkg::ST_NUM:  o_cmd.num  = 1'b1;
            scacc_pkg::ST_PRE:  o_cmd.pre  = 1'b1;
            scacc_pkg::ST_FIX:  o_cmd.fix  = 1'b1;
            scacc_pkg::ST_DIV:  o_cmd.div  = 1'b1;
            scacc_pkg::ST_DONE: begin
                o_cmd.load = !r_out_valid || i_out_ready;
                o_cmd.clr  = !r_out_valid || i_out_ready;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    assign n_out_valid = o_cmd.load || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("input taken while a result is being computed");

    a_dig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scacc_pkg::ST_MUL) |-> (r_dig <= scacc_pkg::DIG_LAST))
        else $error("multiplier digit index out of range");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == scacc_pkg::ST_DONE))
        else $error("result valid raised outside hand-off");

endmodule

`default_nettype wire

FILE: rtl/scacc_dp.sv
// Datapath: running sums, byte-serial shared multiplier, restoring divider
// and rounding into the output register. Depends on scacc_pkg.
`default_nettype none

module scacc_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire scacc_pkg::t_cmd        i_cmd,
    input  wire logic [7:0]             i_data_byte,
    output logic                        o_undef,
    output logic signed [31:0]          o_correlation,
    output logic                        o_undefined,
    output logic                        o_overflowed
);

    localparam int SB = scacc_pkg::SUM_BITS;
    localparam int QB = scacc_pkg::SQ_BITS;
    localparam int PB = scacc_pkg::PROD_BITS;
    localparam int RB = scacc_pkg::REM_BITS;
    localparam int NB = scacc_pkg::Q_BITS;
    localparam int TB = scacc_pkg::SAT_BITS;
    localparam int CB = scacc_pkg::COUNT_BITS;
    localparam int BB = scacc_pkg::BYTE_BITS;

    localparam logic [TB-1:0] NEG_LIMIT = {{(TB-32){1'b0}}, 32'h8000_0000};
    localparam logic [TB-1:0] POS_LIMIT = {{(TB-32){1'b0}}, 32'h7FFF_FFFF};

    logic [CB-1:0]  r_count;
    logic [7:0]     r_first;
    logic [7:0]     r_prev;
    logic [SB-1:0]  r_sum;
    logic [QB-1:0]  r_sq;
    logic [QB-1:0]  r_cross;
    logic           r_drop;
    logic [PB-1:0]  r_s2, r_nq, r_nc;
    logic [PB-1:0]  r_den;
    logic [RB-1:0]  r_rem;
    logic [NB-1:0]  r_q;
    logic           r_neg;
    logic           r_undef;

    logic [QB-1:0]                 w_opa;
    logic [scacc_pkg::OPB_BITS-1:0] w_opb;
    logic [7:0]                    w_digit;
    logic [scacc_pkg::PP_BITS-1:0] w_pp;
    logic [PB-1:0]                 w_pp_sh;
    logic [PB-1:0]                 w_target;
    logic [RB-1:0]                 w_den_x;
    logic [RB-1:0]                 w_rem2;
    logic [NB:0]                   w_qp1;
    logic [TB-1:0]                 w_m;
    logic [31:0]                   w_mag;
    logic [31:0]                   w_res;

    always_comb begin
        case (i_cmd.psel)
            scacc_pkg::PR_SQR: begin
                w_opa    = QB'(r_sum);
                w_opb    = scacc_pkg::OPB_BITS'(r_sum);
                w_target = r_s2;
            end
            scacc_pkg::PR_NQ: begin
                w_opa    = r_sq;
                w_opb    = scacc_pkg::OPB_BITS'(r_count);
                w_target = r_nq;
            end
            default: begin
                w_opa    = r_cross;
                w_opb    = scacc_pkg::OPB_BITS'(r_count);
                w_target = r_nc;
            end
        endcase
        w_digit = w_opb[i_cmd.dig * BB +: BB];
        w_pp    = w_opa * w_digit;
        w_pp_sh = PB'(w_pp) << (i_cmd.dig * BB);
    end

    assign w_den_x = {1'b0, r_den};
    assign w_rem2  = {r_rem[RB-2:0], 1'b0};
    assign w_qp1   = {1'b0, r_q} + 1'b1;
    assign w_m     = TB'(w_qp1[NB:1]);

    always_comb begin
        if (r_neg) begin
            w_mag = (w_m > NEG_LIMIT) ? NEG_LIMIT[31:0] : w_m[31:0];
            w_res = 32'(-w_mag);
        end else begin
            w_mag = (w_m > POS_LIMIT) ? POS_LIMIT[31:0] : w_m[31:0];
            w_res = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_count <= '0;
            r_first <= '0;
            r_prev  <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_cross <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.acc) begin
            if (r_count != {CB{1'b1}}) begin
                if (r_count == '0) begin
                    r_first <= i_data_byte;
                end else begin
                    r_cross <= r_cross + QB'(16'(r_prev) * 16'(i_data_byte));
                end
                r_sum   <= r_sum + SB'(i_data_byte);
                r_sq    <= r_sq + QB'(16'(i_data_byte) * 16'(i_data_byte));
                r_prev  <= i_data_byte;
                r_count <= r_count + 1'b1;
            end else begin
                r_drop <= 1'b1;
            end
        end else if (i_cmd.wrap) begin
            r_cross <= r_cross + QB'(16'(r_prev) * 16'(r_first));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            case (i_cmd.psel)
                scacc_pkg::PR_SQR: r_s2 <= (i_cmd.dig == '0) ? w_pp_sh : w_target + w_pp_sh;
                scacc_pkg::PR_NQ:  r_nq <= (i_cmd.dig == '0) ? w_pp_sh : w_target + w_pp_sh;
                default:           r_nc <= (i_cmd.dig == '0) ? w_pp_sh : w_target + w_pp_sh;
            endcase
        end
        if (i_cmd.den) begin
            r_undef <= (r_count < CB'(2)) || (r_nq <= r_s2);
            r_den   <= r_nq - r_s2;
        end
        if (i_cmd.num) begin
            if (r_nc >= r_s2) begin
                r_rem <= {1'b0, r_nc - r_s2};
                r_neg <= 1'b0;
            end else begin
                r_rem <= {1'b0, r_s2 - r_nc};
                r_neg <= 1'b1;
            end
        end
        if (i_cmd.pre) begin
            if (r_rem >= w_den_x) begin
                r_rem <= r_rem - w_den_x;
                r_q   <= NB'(1);
            end else begin
                r_q   <= '0;
            end
        end
        if (i_cmd.fix) begin
            if (r_rem >= w_den_x) begin
                r_rem <= w_den_x - 1'b1;
            end
        end
        if (i_cmd.div) begin
            if (w_rem2 >= w_den_x) begin
                r_rem <= w_rem2 - w_den_x;
                r_q   <= {r_q[NB-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2;
                r_q   <= {r_q[NB-2:0], 1'b0};
            end
        end
        if (i_cmd.load) begin
            o_correlation <= r_undef ? '0 : w_res;
            o_undefined   <= r_undef;
            o_overflowed  <= r_drop;
        end
    end

    assign o_undef = r_undef;

endmodule

`default_nettype wire

FILE: rtl/serial_correlation_accumulator.sv
// Lag-1 circular serial correlation over a block of bytes. Takes one byte
// transaction per cycle while accumulating. After the byte marked last the
// input stalls while a byte-serial multiplier forms S*S, n*Q and n*C and a
// restoring divider produces one quotient bit per cycle; the divider is skipped
// when the result is undefined. The result waits in an output register, and
// the input is taken again as soon as it is loaded.
// Depends on scacc_pkg, scacc_in_if, scacc_out_if, scacc_ctrl, scacc_dp.
`default_nettype none

module serial_correlation_accumulator (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scacc_in_if.sink    i_in,
    scacc_out_if.source o_out
);

    scacc_pkg::t_cmd w_cmd;
    logic            w_undef;

    scacc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_byte),
        .i_out_ready (o_out.ready),
        .i_undef     (w_undef),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    scacc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_in.data_byte),
        .o_undef       (w_undef),
        .o_correlation (o_out.correlation),
        .o_undefined   (o_out.undefined),
        .o_overflowed  (o_out.overflowed)
    );

endmodule

`default_nettype wire

FILE: tb/sv/serial_correlation_accumulator_checker.sv
`timescale 1ns / 100ps
// Checker for the serial correlation accumulator: watches both channels, predicts
// each result from the accepted bytes and compares it field by field.
// Depends on scacc_pkg, scacc_in_if and scacc_out_if.

module serial_correlation_accumulator_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    scacc_in_if  i_in,
    scacc_out_if i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic signed [31:0] correlation;
        logic               undefined;
        logic               overflowed;
    } t_corr_result;

    logic [scacc_pkg::COUNT_BITS-1:0] block_count;
    logic [7:0]                       block_first;
    logic [7:0]                       block_prev;
    logic [scacc_pkg::SUM_BITS-1:0]   block_sum;
    logic [scacc_pkg::SQ_BITS-1:0]    block_squares;
    logic [scacc_pkg::SQ_BITS-1:0]    block_cross;
    logic                             block_dropped;

    t_corr_result pending_results[$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_results.size();

    task automatic report_fault(input string msg);
        $display("%0t ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic t_corr_result predict_correlation();
        t_corr_result res;
        bit [127:0]   s2;
        bit [127:0]   bottom;
        bit [127:0]   top;
        bit [127:0]   den;
        bit [127:0]   mag;
        bit [127:0]   rem;
        bit [63:0]    wrap_cross;
        bit [63:0]    q;
        bit [63:0]    m;
        bit           neg;
        int           i;
        res.correlation = '0;
        res.undefined   = 1'b1;
        res.overflowed  = block_dropped;
        if (block_count < 2) begin
            return res;
        end
        s2     = 128'(block_sum) * 128'(block_sum);
        bottom = 128'(block_count) * 128'(block_squares);
        if (bottom <= s2) begin
            return res;
        end
        den        = bottom - s2;
        wrap_cross = 64'(block_cross) + 64'(block_prev) * 64'(block_first);
        top        = 128'(block_count) * 128'(wrap_cross);
        neg        = top < s2;
        mag        = neg ? s2 - top : top - s2;
        q   = '0;
        rem = mag;
        if (rem >= den) begin
            rem = rem - den;
            q   = 64'd1;
        end
        if (rem >= den) begin
            rem = den - 128'd1;
        end
        for (i = 0; i <= scacc_pkg::FRACTION_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        m = (q + 64'd1) >> 1;
        res.undefined = 1'b0;
        if (neg) begin
            if (m > 64'h8000_0000) begin
                m = 64'h8000_0000;
            end
            res.correlation = ~m[31:0] + 32'd1;
        end else begin
            if (m > 64'h7FFF_FFFF) begin
                m = 64'h7FFF_FFFF;
            end
            res.correlation = m[31:0];
        end
        return res;
    endfunction

    task automatic clear_block();
        block_count   = '0;
        block_first   = '0;
        block_prev    = '0;
        block_sum     = '0;
        block_squares = '0;
        block_cross   = '0;
        block_dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_corr_result want;
        logic [7:0]   d;
        if (!i_rst_n) begin
            clear_block();
            pending_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    report_fault($sformatf("unexpected result correlation=%0d undefined=%0b",
                                           i_out.correlation, i_out.undefined));
                end else begin
                    want = pending_results.pop_front();
                    if (i_out.correlation !== want.correlation)
                        report_fault($sformatf("correlation got %0d want %0d",
                                               i_out.correlation, want.correlation));
                    if (i_out.undefined !== want.undefined)
                        report_fault($sformatf("undefined got %0b want %0b",
                                               i_out.undefined, want.undefined));
                    if (i_out.overflowed !== want.overflowed)
                        report_fault($sformatf("overflowed got %0b want %0b",
                                               i_out.overflowed, want.overflowed));
                end
            end
            if (i_in.valid && i_in.ready) begin
                d = i_in.data_byte;
                if (block_count != '1) begin
                    if (block_count == '0)
                        block_first = d;
                    else
                        block_cross = block_cross + scacc_pkg::SQ_BITS'(block_prev)
                                      * scacc_pkg::SQ_BITS'(d);
                    block_sum     = block_sum + scacc_pkg::SUM_BITS'(d);
                    block_squares = block_squares + scacc_pkg::SQ_BITS'(d)
                                    * scacc_pkg::SQ_BITS'(d);
                    block_prev    = d;
                    block_count   = block_count + 1'b1;
                end else begin
                    block_dropped = 1'b1;
                end
                if (i_in.last_byte) begin
                    pending_results.push_back(predict_correlation());
                    clear_block();
                end
            end
        end
    end

endmodule

FILE: tb/sv/serial_correlation_accumulator_tb.sv
`timescale 1ns / 100ps
// Top of the serial correlation accumulator testbench: clock, reset, byte blocks
// and result acceptance with random idling; the checker gives the verdict count.
// Depends on serial_correlation_accumulator and serial_correlation_accumulator_checker.

module serial_correlation_accumulator_tb;

    typedef enum int {
        PAT_NOISE,
        PAT_ALTERNATE,
        PAT_FLAT,
        PAT_NARROW
    } t_pattern;

    localparam int RANDOM_BYTES = 1750;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 25;
    localparam int DRAIN_CYCLES = 64;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   bytes_sent = 0;
    int   results_taken = 0;
    bit   send_calm = 1'b0;
    bit   take_calm = 1'b0;

    scacc_in_if  in_ch();
    scacc_out_if out_ch();

    serial_correlation_accumulator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    serial_correlation_accumulator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_block(input logic [7:0] bytes[$]);
        int k;
        for (k = 0; k < bytes.size(); k++)
            send_byte(bytes[k], k == bytes.size() - 1);
    endtask

    initial begin
        int         gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap(take_calm);
            if (results_taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            results_taken++;
        end
    end

    initial begin
        logic [7:0] blk[$];
        logic [7:0] a;
        logic [7:0] b;
        t_pattern   pat;
        int         len;
        int         sel;
        int         k;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single bytes, flat blocks, full-swing alternation, mixed ramps
        send_block('{8'h00});
        send_block('{8'hFF});
        send_block('{8'h00, 8'hFF});
        send_block('{8'hFF, 8'hFF, 8'hFF});
        send_block('{8'h00, 8'h00});
        send_block('{8'h00, 8'hFF, 8'h00, 8'hFF});
        send_block('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h80});
        send_block('{8'h80, 8'h7F, 8'h01, 8'hFE});

        while (bytes_sent < RANDOM_BYTES) begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
                len = 1;
            else if (sel == 1)
                len = $urandom_range(40, 160);
            else
                len = $urandom_range(2, 14);
            pat = t_pattern'($urandom_range(0, 3));
            a   = 8'($urandom_range(0, 255));
            b   = 8'($urandom_range(0, 255));
            blk.delete();
            for (k = 0; k < len; k++) begin
                case (pat)
                    PAT_NOISE: blk.push_back(8'($urandom_range(0, 255)));
                    PAT_ALTERNATE: begin
                        if ($urandom_range(0, 7) == 0)
                            blk.push_back($urandom_range(0, 1) ? a : b);
                        else
                            blk.push_back((k % 2) ? a : b);
                    end
                    PAT_FLAT: blk.push_back(($urandom_range(0, 15) == 0) ? b : a);
                    default: blk.push_back(a + 8'($urandom_range(0, 3)));
                endcase
            end
            send_block(blk);
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/scacc_pkg.sv
rtl/scacc_in_if.sv
rtl/scacc_out_if.sv
rtl/scacc_ctrl.sv
rtl/scacc_dp.sv
rtl/serial_correlation_accumulator.sv
tb/sv/serial_correlation_accumulator_checker.sv
tb/sv/serial_correlation_accumulator_tb.sv
